/* rtl/mlc_pkg.sv */
`default_nettype none

package mlc_pkg;

  typedef logic [1:0] label_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] op_t;
  typedef logic [6:0] dim_t;
  typedef logic [1:0] cfg_idx_t;

  localparam label_t LBL_EXT = 2'd0;
  localparam label_t LBL_INT = 2'd1;
  localparam label_t LBL_BND = 2'd2;
  localparam label_t LBL_DIR = 2'd3;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_QUERY = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_QUERY = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam cfg_idx_t REG_FINE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FINE_HEIGHT = 2'd1;

  typedef struct packed {
    op_t        op;
    logic [5:0] cx;
    logic [5:0] cy;
    label_t     lbl;
    logic       err;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

`default_nettype wire

/* rtl/mlc_in_if.sv */
`default_nettype none

interface mlc_in_if;
  import mlc_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [6:0] fine_x;
  logic [6:0] fine_y;
  label_t     fine_label;
  logic [5:0] coarse_x;
  logic [5:0] coarse_y;

  modport source (
    output valid, kind, fine_x, fine_y, fine_label, coarse_x, coarse_y,
    input  ready
  );
  modport sink (
    input  valid, kind, fine_x, fine_y, fine_label, coarse_x, coarse_y,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/mlc_out_if.sv */
`default_nettype none

interface mlc_out_if;
  import mlc_pkg::*;

  logic   valid;
  logic   ready;
  label_t coarse_label;
  logic   query_error;

  modport source (output valid, coarse_label, query_error, input ready);
  modport sink (input valid, coarse_label, query_error, output ready);
endinterface

`default_nettype wire

/* rtl/mlc_cfg_if.sv */
`default_nettype none

interface mlc_cfg_if;
  import mlc_pkg::*;

  logic       valid;
  logic       ready;
  cfg_idx_t   index;
  logic [7:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* rtl/mlc_ram.sv */
`default_nettype none

module mlc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/mlc_front.sv */
`default_nettype none

module mlc_front (
  mlc_in_if.sink              in_ch,
  input  mlc_pkg::dim_t       cw,
  input  mlc_pkg::dim_t       ch,
  input  mlc_pkg::bk_status_t bk_status,
  output logic                push_valid,
  output mlc_pkg::cmd_t       push_cmd,
  input  logic                push_ready
);
  import mlc_pkg::*;

  logic keep;
  logic in_grid;

  always_comb begin
    push_cmd     = '0;
    push_cmd.lbl = in_ch.fine_label;
    keep         = 1'b0;
    in_grid      = 1'b0;
    case (in_ch.kind)
      KIND_WRITE: begin
        push_cmd.op = OP_WRITE;
        push_cmd.cx = in_ch.fine_x[6:1];
        push_cmd.cy = in_ch.fine_y[6:1];
        in_grid     = ({1'b0, in_ch.fine_x[6:1]} < cw) && ({1'b0, in_ch.fine_y[6:1]} < ch);
        keep        = in_grid && (in_ch.fine_label != LBL_EXT);
      end
      KIND_QUERY: begin
        push_cmd.op  = OP_QUERY;
        push_cmd.cx  = in_ch.coarse_x;
        push_cmd.cy  = in_ch.coarse_y;
        in_grid      = ({1'b0, in_ch.coarse_x} < cw) && ({1'b0, in_ch.coarse_y} < ch);
        push_cmd.err = !in_grid;
        keep         = 1'b1;
      end
      KIND_CLEAR: begin
        push_cmd.op = OP_CLEAR;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = push_ready && !bk_status.clearing;
  assign push_valid  = in_ch.valid && in_ch.ready && keep;

endmodule

`default_nettype wire

/* rtl/mlc_queue.sv */
`default_nettype none

module mlc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  mlc_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output mlc_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import mlc_pkg::*;

  localparam int Q_DEPTH = 2;
  localparam int PW      = $clog2(Q_DEPTH);

  cmd_t          ent_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != (PW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/mlc_back.sv */
`default_nettype none

module mlc_back #(
  parameter int MAX_SIDE = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlc_pkg::dim_t       cw,
  input  mlc_pkg::dim_t       ch,
  input  logic                pop_valid,
  input  mlc_pkg::cmd_t       pop_cmd,
  output logic                pop_ready,
  output mlc_pkg::bk_status_t bk_status,
  mlc_out_if.source           out_ch
);
  import mlc_pkg::*;

  localparam int CSIDE = MAX_SIDE / 2;
  localparam int DEPTH = CSIDE * CSIDE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] ST_CENTER = 3'd0;
  localparam logic [2:0] ST_LEFT   = 3'd1;
  localparam logic [2:0] ST_RIGHT  = 3'd2;
  localparam logic [2:0] ST_UP     = 3'd3;
  localparam logic [2:0] ST_DOWN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  label_t        hold_lbl_r, hold_lbl_nxt;
  logic          hold_err_r, hold_err_nxt;
  logic          out_valid_r, out_valid_nxt;
  label_t        out_lbl_r, out_lbl_nxt;
  logic          out_err_r, out_err_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  label_t        wdata;
  logic [AW-1:0] raddr;
  label_t        rdata;
  logic          out_free;
  logic [2:0]    rd_step;

  function automatic logic [AW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y);
    return AW'(int'(y) * CSIDE + int'(x));
  endfunction

  function automatic logic nb_ok(input logic [2:0] s, input cmd_t c, input dim_t w,
                                 input dim_t h);
    case (s)
      ST_LEFT:  return c.cx != 6'd0;
      ST_RIGHT: return ({1'b0, c.cx} + 7'd1) < w;
      ST_UP:    return c.cy != 6'd0;
      ST_DOWN:  return ({1'b0, c.cy} + 7'd1) < h;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic [5:0] nb_x(input logic [2:0] s, input cmd_t c);
    case (s)
      ST_LEFT:  return c.cx - 6'd1;
      ST_RIGHT: return c.cx + 6'd1;
      default:  return c.cx;
    endcase
  endfunction

  function automatic logic [5:0] nb_y(input logic [2:0] s, input cmd_t c);
    case (s)
      ST_UP:   return c.cy - 6'd1;
      ST_DOWN: return c.cy + 6'd1;
      default: return c.cy;
    endcase
  endfunction

  mlc_ram #(
    .WIDTH ($bits(label_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_step  = step_r + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    clr_cnt_nxt   = clr_cnt_r;
    hold_lbl_nxt  = hold_lbl_r;
    hold_err_nxt  = hold_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_lbl_nxt   = out_lbl_r;
    out_err_nxt   = out_err_r;
    we            = 1'b0;
    waddr         = cell_addr(cur_r.cx, cur_r.cy);
    wdata         = LBL_EXT;
    raddr         = cell_addr(pop_cmd.cx, pop_cmd.cy);
    pop_ready     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        wdata = LBL_EXT;
        if (clr_cnt_r == AW'(DEPTH-1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_nxt = pop_cmd;
          case (pop_cmd.op)
            OP_WRITE: begin
              state_nxt = S_WRITE;
            end
            OP_QUERY: begin
              if (pop_cmd.err) begin
                hold_lbl_nxt = LBL_EXT;
                hold_err_nxt = 1'b1;
                state_nxt    = S_OUT;
              end else begin
                step_nxt  = ST_CENTER;
                state_nxt = S_QRY;
              end
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WRITE: begin
        we        = 1'b1;
        wdata     = (cur_r.lbl == LBL_DIR || rdata == LBL_DIR) ? LBL_DIR : LBL_INT;
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        raddr    = nb_ok(rd_step, cur_r, cw, ch) ?
                   cell_addr(nb_x(rd_step, cur_r), nb_y(rd_step, cur_r)) :
                   cell_addr(cur_r.cx, cur_r.cy);
        step_nxt = rd_step;
        if (step_r == ST_CENTER) begin
          if (rdata != LBL_INT) begin
            hold_lbl_nxt = rdata;
            hold_err_nxt = 1'b0;
            state_nxt    = S_OUT;
          end
        end else if (!nb_ok(step_r, cur_r, cw, ch) || rdata == LBL_EXT ||
                     rdata == LBL_DIR) begin
          hold_lbl_nxt = LBL_BND;
          hold_err_nxt = 1'b0;
          state_nxt    = S_OUT;
        end else if (step_r == ST_DOWN) begin
          hold_lbl_nxt = LBL_INT;
          hold_err_nxt = 1'b0;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_lbl_nxt   = hold_lbl_r;
          out_err_nxt   = hold_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    step_r     <= step_nxt;
    hold_lbl_r <= hold_lbl_nxt;
    hold_err_r <= hold_err_nxt;
    out_lbl_r  <= out_lbl_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign bk_status.clearing = (state_r == S_CLEAR);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.coarse_label = out_lbl_r;
  assign out_ch.query_error  = out_err_r;

endmodule

`default_nettype wire

/* rtl/multigrid_label_coarsener.sv */
`default_nettype none

// Coarse level builder for a 2D multigrid cell label grid. Fine cell writes are merged
// into their 2x2 parent in a (MAX_SIDE/2)^2 entry single-port-read store; queries return
// the coarse label, with interior cells next to exterior, Dirichlet or off-grid
// neighbours reported as boundary; a clear transaction empties the store. Items are
// classified on entry and held in a two-entry queue, so items can be taken until it fills
// while a result waits on the output register. The store has one read port: a write reads,
// then merges and writes; a query reads the centre and then each neighbour in turn,
// stopping early, then moves into the output register; an off-grid query goes straight
// to the output register; a clear rewrites the store one entry a cycle; ignored items are
// dropped on entry. After reset the store is swept to exterior, during which no input
// transaction is taken; configuration writes are taken at any time and should only be
// made while the block is idle.

module multigrid_label_coarsener #(
  parameter int MAX_SIDE = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  mlc_in_if.sink     in_ch,
  mlc_out_if.source  out_ch,
  mlc_cfg_if.sink    cfg_ch
);
  import mlc_pkg::*;

  localparam int CSIDE   = MAX_SIDE / 2;
  localparam int DIM_LIM = (CSIDE < 64) ? CSIDE : 64;

  logic [7:0] fine_width_r;
  logic [7:0] fine_height_r;
  dim_t       cw;
  dim_t       ch;
  logic       q_push_valid;
  cmd_t       q_push_cmd;
  logic       q_push_ready;
  logic       q_pop_valid;
  cmd_t       q_pop_cmd;
  logic       q_pop_ready;
  bk_status_t bk_status;

  function automatic dim_t coarse_dim(input logic [7:0] r);
    dim_t c;
    c = r[7:1];
    return (c > dim_t'(DIM_LIM)) ? dim_t'(DIM_LIM) : c;
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_width_r  <= 8'd128;
      fine_height_r <= 8'd128;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_FINE_WIDTH:  fine_width_r  <= cfg_ch.wdata;
        REG_FINE_HEIGHT: fine_height_r <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  assign cw = coarse_dim(fine_width_r);
  assign ch = coarse_dim(fine_height_r);

  mlc_front u_front (
    .in_ch      (in_ch),
    .cw         (cw),
    .ch         (ch),
    .bk_status  (bk_status),
    .push_valid (q_push_valid),
    .push_cmd   (q_push_cmd),
    .push_ready (q_push_ready)
  );

  mlc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_cmd   (q_push_cmd),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_cmd    (q_pop_cmd),
    .pop_ready  (q_pop_ready)
  );

  mlc_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw        (cw),
    .ch        (ch),
    .pop_valid (q_pop_valid),
    .pop_cmd   (q_pop_cmd),
    .pop_ready (q_pop_ready),
    .bk_status (bk_status),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  a_no_input_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) bk_status.clearing |-> !in_ch.ready
  ) else $error("input taken during store clear");

  a_reset_starts_clear: assert property (
    @(posedge clk) !rst_n |=> bk_status.clearing
  ) else $error("store clear not started after reset");

  a_push_has_room: assert property (
    @(posedge clk) disable iff (!rst_n) q_push_valid |-> q_push_ready
  ) else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import mlc_pkg::*;

  localparam int MAX_SIDE        = 128;
  localparam int CSIDE           = MAX_SIDE / 2;
  localparam int STORE_DEPTH     = CSIDE * CSIDE;
  localparam int SETTLE_CYCLES   = STORE_DEPTH + 64;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 1_500_000;

  localparam kind_t    KIND_UNUSED = 2'd3;
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] fx;
    logic [6:0] fy;
    label_t     lbl;
    logic [5:0] cx;
    logic [5:0] cy;
  } cell_item_t;

  typedef struct packed {
    label_t lbl;
    logic   err;
  } coarse_result_t;

  typedef enum logic [2:0] {ROW_WRITE, ROW_QUERY, ROW_CLEAR, ROW_SKIP, ROW_SIZE} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
    label_t     lbl;
    logic       typed;
    label_t     exp_lbl;
    logic       exp_err;
  } directed_row_t;

  // a, b: fine coords for writes, coarse coords for queries, register values for sizes
  localparam directed_row_t DIRECTED_ROWS [28] = '{
    '{ROW_QUERY, 8'd0,   8'd0,   LBL_EXT, 1'b1, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd63,  8'd63,  LBL_EXT, 1'b1, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd0,   8'd0,   LBL_INT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd1,   8'd1,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd0,   8'd0,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd127, 8'd127, LBL_DIR, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd63,  8'd63,  LBL_EXT, 1'b1, LBL_DIR, 1'b0},
    '{ROW_WRITE, 8'd2,   8'd0,   LBL_BND, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd1,   8'd0,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd3,   8'd1,   LBL_DIR, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd3,   8'd0,   LBL_INT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd1,   8'd0,   LBL_EXT, 1'b1, LBL_DIR, 1'b0},
    '{ROW_QUERY, 8'd0,   8'd0,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_SKIP,  8'd0,   8'd0,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_CLEAR, 8'd0,   8'd0,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd63,  8'd63,  LBL_EXT, 1'b1, LBL_EXT, 1'b0},
    '{ROW_SIZE,  8'd10,  8'd6,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd10,  8'd0,   LBL_INT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd9,   8'd5,   LBL_INT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd5,   8'd0,   LBL_EXT, 1'b1, LBL_EXT, 1'b1},
    '{ROW_QUERY, 8'd0,   8'd3,   LBL_EXT, 1'b1, LBL_EXT, 1'b1},
    '{ROW_QUERY, 8'd4,   8'd2,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_SIZE,  8'd1,   8'd255, LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_WRITE, 8'd0,   8'd0,   LBL_DIR, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd0,   8'd0,   LBL_EXT, 1'b1, LBL_EXT, 1'b1},
    '{ROW_SIZE,  8'd255, 8'd128, LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd4,   8'd2,   LBL_EXT, 1'b0, LBL_EXT, 1'b0},
    '{ROW_QUERY, 8'd5,   8'd2,   LBL_EXT, 1'b0, LBL_EXT, 1'b0}
  };

  logic clk;
  logic rst_n;

  mlc_in_if  in_ch ();
  mlc_out_if out_ch ();
  mlc_cfg_if cfg_ch ();

  multigrid_label_coarsener #(.MAX_SIDE(MAX_SIDE)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  label_t         coarse_shadow [STORE_DEPTH];
  logic [7:0]     fine_w_shadow;
  logic [7:0]     fine_h_shadow;
  coarse_result_t pending_coarse [$];

  bit tx_quiet;
  bit rx_quiet;
  bit hold_off_req;

  int failures;
  int cycle_count;
  int effective_items;
  int n_queries;
  int n_clears;
  int n_sizes;
  int n_results;
  int n_err_results;
  int n_interior;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int coarse_side(logic [7:0] r);
    int c;
    c = int'(r >> 1);
    return (c > CSIDE) ? CSIDE : c;
  endfunction

  // neighbour off the grid, exterior or Dirichlet
  function automatic bit open_side(int x, int y, int cw, int ch);
    label_t n;
    if (x < 0 || y < 0 || x >= cw || y >= ch) return 1'b1;
    n = coarse_shadow[y * CSIDE + x];
    return (n == LBL_EXT) || (n == LBL_DIR);
  endfunction

  // updates the shadow store; returns 1 unless the item is an off-grid write or of an unused kind
  function automatic bit predict_coarse(input cell_item_t it, output bit has_res,
                                        output coarse_result_t res);
    int cw, ch, x, y, addr;
    label_t s;
    cw = coarse_side(fine_w_shadow);
    ch = coarse_side(fine_h_shadow);
    has_res = 1'b0;
    res = '0;
    case (it.kind)
      KIND_WRITE: begin
        x = int'(it.fx >> 1);
        y = int'(it.fy >> 1);
        if (x >= cw || y >= ch) return 1'b0;
        addr = y * CSIDE + x;
        if (it.lbl == LBL_DIR) begin
          coarse_shadow[addr] = LBL_DIR;
        end else if ((it.lbl == LBL_INT || it.lbl == LBL_BND) &&
                     coarse_shadow[addr] != LBL_DIR) begin
          coarse_shadow[addr] = LBL_INT;
        end
        return 1'b1;
      end
      KIND_QUERY: begin
        has_res = 1'b1;
        x = int'(it.cx);
        y = int'(it.cy);
        if (x >= cw || y >= ch) begin
          res.lbl = LBL_EXT;
          res.err = 1'b1;
          return 1'b1;
        end
        s = coarse_shadow[y * CSIDE + x];
        if (s == LBL_INT && (open_side(x - 1, y, cw, ch) || open_side(x + 1, y, cw, ch) ||
                             open_side(x, y - 1, cw, ch) || open_side(x, y + 1, cw, ch)))
          s = LBL_BND;
        res.lbl = s;
        return 1'b1;
      end
      KIND_CLEAR: begin
        foreach (coarse_shadow[i]) coarse_shadow[i] = LBL_EXT;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly back to back or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic label_t pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return LBL_EXT;
    if (r < 55) return LBL_INT;
    if (r < 90) return LBL_BND;
    return LBL_DIR;
  endfunction

  function automatic cell_item_t random_item(kind_t k);
    cell_item_t it;
    it.kind = k;
    it.fx   = 7'($urandom_range(0, 127));
    it.fy   = 7'($urandom_range(0, 127));
    it.lbl  = 2'($urandom_range(0, 3));
    it.cx   = 6'($urandom_range(0, 63));
    it.cy   = 6'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic send_item(input cell_item_t it, input bit typed = 1'b0,
                           input coarse_result_t typed_res = '0);
    int gap;
    bit has_res;
    coarse_result_t res;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.fine_x     <= it.fx;
    in_ch.fine_y     <= it.fy;
    in_ch.fine_label <= it.lbl;
    in_ch.coarse_x   <= it.cx;
    in_ch.coarse_y   <= it.cy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_coarse(it, has_res, res)) effective_items++;
    if (has_res) pending_coarse.insert(pending_coarse.size(), typed ? typed_res : res);
    if (it.kind == KIND_QUERY) n_queries++;
    if (it.kind == KIND_CLEAR) n_clears++;
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_coarse.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_FINE_WIDTH) fine_w_shadow = d;
    else if (idx == REG_FINE_HEIGHT) fine_h_shadow = d;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // writes and clears give no result, so wait out a full sweep before touching the size
  task automatic change_size(logic [7:0] fw, logic [7:0] fh);
    pause_input();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_FINE_WIDTH, fw);
    write_reg(REG_FINE_HEIGHT, fh);
    write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3, 8'($urandom_range(0, 255)));
    n_sizes++;
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 99);
    send_item(random_item(r < 40 ? KIND_WRITE : (r < 85 ? KIND_QUERY : KIND_UNUSED)));
  endtask

  // may clear; fill a small patch of coarse cells, then query most of it and its rim
  task automatic send_patch();
    int cw, ch, x0, y0, w, h, kids;
    cell_item_t it;
    cw = coarse_side(fine_w_shadow);
    ch = coarse_side(fine_h_shadow);
    if ($urandom_range(0, 99) < 3) send_item(random_item(KIND_CLEAR));
    if (cw == 0 || ch == 0) begin
      send_noise();
      return;
    end
    x0 = $urandom_range(0, cw - 1);
    y0 = $urandom_range(0, ch - 1);
    w  = $urandom_range(1, (cw - x0 < 5) ? cw - x0 : 5);
    h  = $urandom_range(1, (ch - y0 < 5) ? ch - y0 : 5);
    for (int y = y0; y < y0 + h; y++) begin
      for (int x = x0; x < x0 + w; x++) begin
        kids = $urandom_range(1, 2);
        for (int k = 0; k < kids; k++) begin
          it = random_item(KIND_WRITE);
          it.fx  = 7'(2 * x + $urandom_range(0, 1));
          it.fy  = 7'(2 * y + $urandom_range(0, 1));
          it.lbl = pick_label();
          send_item(it);
        end
      end
    end
    for (int y = y0 - 1; y <= y0 + h; y++) begin
      for (int x = x0 - 1; x <= x0 + w; x++) begin
        if ($urandom_range(0, 99) < 75) begin
          it = random_item(KIND_QUERY);
          it.cx = 6'(x);
          it.cy = 6'(y);
          send_item(it);
        end
      end
    end
  endtask

  task automatic run_phase(logic [7:0] fw, logic [7:0] fh, int n_items, bit quiet);
    int start;
    change_size(fw, fh);
    tx_quiet = quiet;
    rx_quiet = quiet;
    start = effective_items;
    while (effective_items - start < n_items) begin
      if ($urandom_range(0, 99) < 12) send_noise();
      else send_patch();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // output held off while queries keep coming, then a full drain
  task automatic query_burst();
    hold_off_req = 1'b1;
    tx_quiet = 1'b1;
    for (int k = 0; k < 48; k++) send_item(random_item(KIND_QUERY));
    tx_quiet = 1'b0;
    pause_input();
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = pick_gap(rx_quiet);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    coarse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.query_error) n_err_results++;
      if (out_ch.coarse_label == LBL_INT) n_interior++;
      if (pending_coarse.size() == 0) begin
        $error("unexpected result transaction: coarse_label %0d query_error %0d",
               out_ch.coarse_label, out_ch.query_error);
        failures++;
      end else begin
        want = pending_coarse.pop_front();
        if (out_ch.coarse_label !== want.lbl) begin
          $error("coarse_label: expected %0d, got %0d", want.lbl, out_ch.coarse_label);
          failures++;
        end
        if (out_ch.query_error !== want.err) begin
          $error("query_error: expected %0d, got %0d", want.err, out_ch.query_error);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** multigrid_label_coarsener: FAILED **");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    cell_item_t it;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_WRITE;
    in_ch.fine_x     <= '0;
    in_ch.fine_y     <= '0;
    in_ch.fine_label <= LBL_EXT;
    in_ch.coarse_x   <= '0;
    in_ch.coarse_y   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_FINE_WIDTH;
    cfg_ch.wdata     <= '0;
    foreach (coarse_shadow[i]) coarse_shadow[i] = LBL_EXT;
    fine_w_shadow = 8'd128;
    fine_h_shadow = 8'd128;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      it = random_item(KIND_WRITE);
      case (row.op)
        ROW_WRITE: begin
          it.fx  = row.a[6:0];
          it.fy  = row.b[6:0];
          it.lbl = row.lbl;
        end
        ROW_QUERY: begin
          it.kind = KIND_QUERY;
          it.cx   = row.a[5:0];
          it.cy   = row.b[5:0];
        end
        ROW_CLEAR: it.kind = KIND_CLEAR;
        ROW_SKIP:  it = '1;
        default:   change_size(row.a, row.b);
      endcase
      if (row.op != ROW_SIZE) send_item(it, row.typed, {row.exp_lbl, row.exp_err});
    end

    run_phase(8'd128, 8'd128, 160, 1'b0);
    query_burst();
    run_phase(8'd255, 8'd201, 160, 1'b0);
    run_phase(8'd2, 8'd2, 120, 1'b0);
    run_phase(8'd0, 8'd77, 60, 1'b0);
    run_phase(8'd37, 8'd130, 160, 1'b1);
    run_phase(8'd16, 8'd16, 160, 1'b0);
    run_phase(8'($urandom_range(2, 255)), 8'($urandom_range(2, 255)), 160, 1'b0);
    run_phase(8'd129, 8'd3, 140, 1'b0);

    pause_input();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d input transactions (%0d queries, %0d clears) over %0d grid sizes",
             effective_items, n_queries, n_clears, n_sizes);
    $display("%0d results checked: %0d off-grid errors, %0d plain interior labels",
             n_results, n_err_results, n_interior);
    if (failures == 0) begin
      $display("** multigrid_label_coarsener: PASSED **");
    end else begin
      $display("** multigrid_label_coarsener: FAILED **");
    end
    $finish;
  end

endmodule
